// ===== sv/dual_lane_fnv_prefix_hash_chain_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual-lane FNV prefix hash chain
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef DUAL_LANE_FNV_PREFIX_HASH_CHAIN_MACROS_SVH
`define DUAL_LANE_FNV_PREFIX_HASH_CHAIN_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define FNVPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fnvph next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define FNVPH_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fnvph reset check failed");

`endif

// ===== sv/fnvph_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvph_pkg
// Constants and types shared by the dual-lane FNV prefix hash chain.
// ----------------------------------------------------------------------------
package fnvph_pkg;

   localparam logic [63:0] FNV_OFFSET   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] LANE_XOR     = 64'hA5A5_A5A5_A5A5_A5A5;
   localparam logic [63:0] HIGH_OFFSET  = FNV_OFFSET ^ LANE_XOR;
   localparam logic [31:0] TALLY_MAX    = 32'hFFFF_FFFF;

   localparam int TOKEN_BYTES = 17;
   localparam int RAW_BYTES   = 8;
   localparam int BUF_W       = TOKEN_BYTES * 8;
   localparam int CNT_W       = $clog2(TOKEN_BYTES + 1);

   localparam logic OP_TOKEN = 1'b0;
   localparam logic OP_RAW   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_EMIT
   } fnvph_state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } fnvph_seq_ctl_type;

   typedef struct packed {
      logic busy;
      logic last;
   } fnvph_seq_stat_type;

endpackage

// ===== sv/fnvph_if.sv =====
// ----------------------------------------------------------------------------
// fnvph_req_if / fnvph_rsp_if
// Valid/ready channels for input items and hash result items.
// ----------------------------------------------------------------------------
interface fnvph_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] token_id;
   logic        [7:0]  token_type;
   logic signed [31:0] position_a;
   logic signed [31:0] position_b;
   logic signed [31:0] position_c;
   logic        [63:0] raw_value;
   logic        [3:0]  raw_bytes;
   logic               restart;
   logic               close_prefix;

   modport source (
      output valid, operation, token_id, token_type, position_a, position_b,
             position_c, raw_value, raw_bytes, restart, close_prefix,
      input  ready
   );
   modport sink (
      input  valid, operation, token_id, token_type, position_a, position_b,
             position_c, raw_value, raw_bytes, restart, close_prefix,
      output ready
   );
endinterface

interface fnvph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_low;
   logic [63:0] hash_high;
   logic [31:0] prefix_tokens;

   modport source (
      output valid, hash_low, hash_high, prefix_tokens,
      input  ready
   );
   modport sink (
      input  valid, hash_low, hash_high, prefix_tokens,
      output ready
   );
endinterface

// ===== sv/fnvph_step.sv =====
// ----------------------------------------------------------------------------
// fnvph_step
// Shared FNV-1a byte step for both lanes: xor the byte, multiply by the prime.
// ----------------------------------------------------------------------------
module fnvph_step
   import fnvph_pkg::*;
(
   input  logic [63:0] lane_low,
   input  logic [63:0] lane_high,
   input  logic [7:0]  data_byte,
   output logic [63:0] next_low,
   output logic [63:0] next_high
);

   // The prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
   function automatic logic [63:0] mul_prime(input logic [63:0] x);
      mul_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                + (x << 1) + x;
   endfunction

   assign next_low  = mul_prime(lane_low  ^ {56'd0, data_byte});
   assign next_high = mul_prime(lane_high ^ {56'd0, data_byte});

endmodule

// ===== sv/fnvph_byte_seq.sv =====
// ----------------------------------------------------------------------------
// fnvph_byte_seq
// Holds the bytes of one item and presents them lowest first, one per step.
// ----------------------------------------------------------------------------
module fnvph_byte_seq
   import fnvph_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  fnvph_seq_ctl_type  ctl,
   input  logic [BUF_W-1:0]   load_data,
   input  logic [CNT_W-1:0]   load_count,
   output logic [7:0]         cur_byte,
   output fnvph_seq_stat_type stat
);

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      if (ctl.load) begin
         buf_in   = load_data;
         count_in = load_count;
      end else if (ctl.advance && (count_ff != '0)) begin
         buf_in   = buf_ff >> 8;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign cur_byte  = buf_ff[7:0];
   assign stat.busy = (count_ff != '0);
   assign stat.last = (count_ff == CNT_W'(1));

endmodule

// ===== sv/dual_lane_fnv_prefix_hash_chain.sv =====
// ----------------------------------------------------------------------------
// dual_lane_fnv_prefix_hash_chain
// Two 64-bit FNV-1a lanes over token records and raw words, with prefix close.
// ----------------------------------------------------------------------------
// The block absorbs one item at a time, one byte per clock, into two FNV-1a
// lanes that share the prime 0x100000001B3: the low lane starts at the standard
// offset and the high lane at that offset xored with 0xA5A5A5A5A5A5A5A5. A
// token record feeds 17 bytes (id, type byte, three positions, all
// little-endian) and bumps a saturating token count; a raw item feeds the low
// raw_bytes bytes of raw_value, clamped to eight. With restart set the lanes
// and the count are reloaded before the item is absorbed; with close_prefix
// set one result item carrying both lanes and the count is produced after it.
// An item is loaded into the byte sequencer on acceptance, absorbed byte by
// byte in the absorb state, and then passes the emit state before the block is
// ready again; a raw item with no bytes still passes through the absorb state.
// The block's pace is set by the single byte-step unit, which updates both
// lanes together on each step, walked through the item's bytes by the byte
// sequencer. The result sits in an output register, so the next item can be
// taken while a result still waits; only when a second close arrives before
// the first result is taken does the block hold in its emit state, until the
// receiver takes the first result.

module dual_lane_fnv_prefix_hash_chain
   import fnvph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fnvph_req_if.sink   req_if,
   fnvph_rsp_if.source rsp_if
);

   fnvph_state_type state_ff, state_in;

   logic [63:0] lane_low_ff, lane_low_in;
   logic [63:0] lane_high_ff, lane_high_in;
   logic [31:0] tally_ff, tally_in;
   logic        close_ff, close_in;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_low_ff, out_high_ff;
   logic [31:0] out_tokens_ff;
   logic        out_load;

   logic               accept;
   fnvph_seq_ctl_type  seq_ctl;
   fnvph_seq_stat_type seq_stat;
   logic [BUF_W-1:0]   load_data;
   logic [CNT_W-1:0]   load_count;
   logic [7:0]         cur_byte;
   logic [63:0]        step_low, step_high;
   logic [31:0]        tally_base;

   // The block takes an item only when it is idle and out of reset.
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_if.valid && req_if.ready;

   // Byte image of the incoming item, lowest byte absorbed first.
   always_comb begin
      if (req_if.operation == OP_TOKEN) begin
         load_data  = {req_if.position_c, req_if.position_b, req_if.position_a,
                       req_if.token_type, req_if.token_id};
         load_count = CNT_W'(TOKEN_BYTES);
      end else begin
         load_data = {{(BUF_W - 64){1'b0}}, req_if.raw_value};
         if (req_if.raw_bytes > 4'(RAW_BYTES)) begin
            load_count = CNT_W'(RAW_BYTES);
         end else begin
            load_count = CNT_W'(req_if.raw_bytes);
         end
      end
   end

   fnvph_byte_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (seq_ctl),
      .load_data  (load_data),
      .load_count (load_count),
      .cur_byte   (cur_byte),
      .stat       (seq_stat)
   );

   fnvph_step u_step (
      .lane_low  (lane_low_ff),
      .lane_high (lane_high_ff),
      .data_byte (cur_byte),
      .next_low  (step_low),
      .next_high (step_high)
   );

   // Restart clears the count before this item's own token is counted.
   assign tally_base = req_if.restart ? 32'd0 : tally_ff;

   always_comb begin
      state_in     = state_ff;
      lane_low_in  = lane_low_ff;
      lane_high_in = lane_high_ff;
      tally_in     = tally_ff;
      close_in     = close_ff;
      seq_ctl      = '0;
      out_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_ctl.load = 1'b1;
               close_in     = req_if.close_prefix;
               state_in     = ST_ABSORB;
               if (req_if.restart) begin
                  lane_low_in  = FNV_OFFSET;
                  lane_high_in = HIGH_OFFSET;
               end
               if ((req_if.operation == OP_TOKEN) && (tally_base != TALLY_MAX)) begin
                  tally_in = tally_base + 32'd1;
               end else begin
                  tally_in = tally_base;
               end
            end
         end
         ST_ABSORB: begin
            // One byte through the shared step unit per cycle.
            if (seq_stat.busy) begin
               seq_ctl.advance = 1'b1;
               lane_low_in     = step_low;
               lane_high_in    = step_high;
               if (seq_stat.last) begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!close_ff) begin
               state_in = ST_IDLE;
            end else if (!out_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lane_low_ff  <= FNV_OFFSET;
         lane_high_ff <= HIGH_OFFSET;
         tally_ff     <= 32'd0;
         close_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_low_ff  <= lane_low_in;
         lane_high_ff <= lane_high_in;
         tally_ff     <= tally_in;
         close_ff     <= close_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload carries no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_low_ff    <= lane_low_ff;
         out_high_ff   <= lane_high_ff;
         out_tokens_ff <= tally_ff;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.hash_low      = out_low_ff;
   assign rsp_if.hash_high     = out_high_ff;
   assign rsp_if.prefix_tokens = out_tokens_ff;

endmodule

// ===== sv/fnvph_checker.sv =====
// ----------------------------------------------------------------------------
// fnvph_checker
// Port-level checks on the dual-lane FNV prefix hash chain, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_lane_fnv_prefix_hash_chain_macros.svh"

module fnvph_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_close_prefix,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_low,
   input logic [63:0] rsp_hash_high,
   input logic [31:0] rsp_prefix_tokens
);

   // A waiting result item keeps its contents until it is taken.
   `FNVPH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hash_low) && $stable(rsp_hash_high) && $stable(rsp_prefix_tokens))

   // An accepted item occupies the block for at least the following cycle.
   `FNVPH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // Reset empties the result register.
   `FNVPH_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // An item without close never makes a new result appear right after it.
   `FNVPH_ASSERT_NEXT(a_no_close_no_rsp, clock, reset, req_valid && req_ready && !req_close_prefix && !rsp_valid, !rsp_valid)

endmodule

bind dual_lane_fnv_prefix_hash_chain fnvph_checker u_fnvph_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_close_prefix  (req_if.close_prefix),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_hash_low      (rsp_if.hash_low),
   .rsp_hash_high     (rsp_if.hash_high),
   .rsp_prefix_tokens (rsp_if.prefix_tokens)
);
